/* hw/rtl/fps_pkg.sv */
package fps_pkg;

  localparam int MAX_POINTS  = 4096;
  localparam int IDX_BITS    = $clog2(MAX_POINTS);
  localparam int CNT_BITS    = IDX_BITS + 1;
  localparam int COORD_BITS  = 16;
  localparam int DIFF_BITS   = COORD_BITS + 1;
  localparam int SQ_BITS     = 2 * COORD_BITS + 1;
  localparam int DIST_BITS   = 2 * COORD_BITS + 2;
  localparam int POINT_BITS  = 3 * COORD_BITS;
  localparam int MAX_SAMPLES = 64;
  localparam int SCOUNT_BITS = 7;
  localparam int SCOUNT_RESET = 16;
  localparam int OUT_BITS    = 16;

endpackage

/* hw/rtl/farthest_point_sampler_top.sv */
// Channel   Direction  Payload
// s_*       in         tdata: coord_x [15:0], coord_y [31:16], coord_z [47:32];
//                      tlast: last_point
// m_*       out        tdata: sample_index [11:0], zero fill [15:12];
//                      tlast: last_sample
// cfg_*     in         cfg_data: sample_count, written when cfg_we is high
//
// Loading goes on at one point per cycle. After the last point the sampler works alone
// with s_tready low. When all points are requested it emits one index per cycle while
// m_tready stays high. Otherwise every index past the first costs one fetch of the chosen
// point plus a sweep of N reads of the point and distance memories, a drain of the
// four-stage distance pipeline and a decision state. The single read port of each memory
// sets the length of the sweep. A stalled m_tready holds the sampler only in the states
// that emit an index. Reset (rst, synchronous) clears control state only; the memories
// need no clearing pass, since only entries written during the current load are read.
module farthest_point_sampler_top (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [fps_pkg::POINT_BITS-1:0]         s_tdata,   // coord_x, coord_y, coord_z
  input  logic                                   s_tlast,   // last_point
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [fps_pkg::OUT_BITS-1:0]           m_tdata,   // sample_index, zero fill
  output logic                                   m_tlast,   // last_sample
  input  logic                                   cfg_we,
  input  logic [fps_pkg::SCOUNT_BITS-1:0]        cfg_data
);

  typedef enum logic [2:0] {
    ST_LOAD, ST_ENUM, ST_FETCH, ST_LATCH, ST_SWEEP, ST_DRAIN, ST_DECIDE, ST_FINISH
  } state_t;

  localparam int CB = fps_pkg::COORD_BITS;

  state_t state;

  // Configuration and run bookkeeping.
  logic [fps_pkg::SCOUNT_BITS-1:0] sample_count;
  logic [fps_pkg::SCOUNT_BITS-1:0] want;
  logic [fps_pkg::CNT_BITS-1:0]    points_loaded;
  logic [fps_pkg::CNT_BITS-1:0]    n_pts;
  logic [fps_pkg::SCOUNT_BITS-1:0] count;       // indices chosen so far, pending one included
  logic [fps_pkg::IDX_BITS-1:0]    pend_idx;    // chosen but not yet emitted
  logic [fps_pkg::CNT_BITS-1:0]    walk;        // sweep read address and enumeration index

  // Output register.
  logic                            out_valid;
  logic [fps_pkg::IDX_BITS-1:0]    out_index;
  logic                            out_last;
  logic                            out_free;
  logic                            out_load;

  // Memories and their ports.
  logic [fps_pkg::POINT_BITS-1:0]  point_mem [fps_pkg::MAX_POINTS];
  logic [fps_pkg::DIST_BITS-1:0]   dist_mem  [fps_pkg::MAX_POINTS];
  logic                            pt_we;
  logic [fps_pkg::IDX_BITS-1:0]    pt_raddr;
  logic [fps_pkg::POINT_BITS-1:0]  pt_rdata;
  logic                            dist_we;
  logic [fps_pkg::IDX_BITS-1:0]    dist_waddr;
  logic [fps_pkg::DIST_BITS-1:0]   dist_wdata;
  logic [fps_pkg::DIST_BITS-1:0]   dist_rdata;

  // Current center point and distance pipeline.
  logic [fps_pkg::POINT_BITS-1:0]  cur_pt;
  logic                            v1, va, vb, vc;
  logic [fps_pkg::IDX_BITS-1:0]    idx1, idxa, idxb, idxc;
  logic [fps_pkg::DIST_BITS-1:0]   dista, distb, distc;
  logic signed [fps_pkg::DIFF_BITS-1:0] dxa, dya, dza;
  logic [fps_pkg::SQ_BITS-1:0]     sqxb, sqyb, sqzb;
  logic [fps_pkg::DIST_BITS-1:0]   sumc;
  logic signed [fps_pkg::DIFF_BITS-1:0] dx, dy, dz;
  logic signed [2*fps_pkg::DIFF_BITS-1:0] px, py, pz;
  logic [fps_pkg::DIST_BITS:0]     sum_full;
  logic [fps_pkg::DIST_BITS-1:0]   new_dist;
  logic [fps_pkg::DIST_BITS-1:0]   best;
  logic [fps_pkg::IDX_BITS-1:0]    best_idx;

  logic                            s_acc;
  logic                            room;
  logic [fps_pkg::CNT_BITS-1:0]    n_next;

  assign s_tready = (state == ST_LOAD);
  assign s_acc    = s_tvalid && s_tready;
  assign room     = points_loaded < fps_pkg::CNT_BITS'(fps_pkg::MAX_POINTS);
  assign n_next   = room ? points_loaded + 1'b1 : points_loaded;
  assign out_free = !out_valid || m_tready;
  // The output register takes a new index in this cycle.
  assign out_load = out_free &&
                    (state == ST_ENUM || state == ST_DECIDE || state == ST_FINISH);

  assign m_tvalid = out_valid;
  assign m_tdata  = fps_pkg::OUT_BITS'(out_index);
  assign m_tlast  = out_last;

  // A zero count behaves as one, anything above the limit as the limit.
  always_comb begin
    if (sample_count == '0) begin
      want = fps_pkg::SCOUNT_BITS'(1);
    end else if (sample_count > fps_pkg::SCOUNT_BITS'(fps_pkg::MAX_SAMPLES)) begin
      want = fps_pkg::SCOUNT_BITS'(fps_pkg::MAX_SAMPLES);
    end else begin
      want = sample_count;
    end
  end

  // Difference to the current center, squares and their sum.
  always_comb begin
    dx = $signed({pt_rdata[CB-1], pt_rdata[CB-1:0]}) -
         $signed({cur_pt[CB-1], cur_pt[CB-1:0]});
    dy = $signed({pt_rdata[2*CB-1], pt_rdata[2*CB-1:CB]}) -
         $signed({cur_pt[2*CB-1], cur_pt[2*CB-1:CB]});
    dz = $signed({pt_rdata[3*CB-1], pt_rdata[3*CB-1:2*CB]}) -
         $signed({cur_pt[3*CB-1], cur_pt[3*CB-1:2*CB]});
    px = dxa * dxa;
    py = dya * dya;
    pz = dza * dza;
    sum_full = (fps_pkg::DIST_BITS+1)'(sqxb) + (fps_pkg::DIST_BITS+1)'(sqyb) +
               (fps_pkg::DIST_BITS+1)'(sqzb);
    new_dist = (sumc < distc) ? sumc : distc;
  end

  // Memory port selection: loading writes fresh entries, the sweep writes lowered ones.
  always_comb begin
    pt_we      = s_acc && room;
    dist_we    = 1'b0;
    dist_waddr = points_loaded[fps_pkg::IDX_BITS-1:0];
    dist_wdata = '1;
    if (s_acc && room) begin
      dist_we = 1'b1;
    end else if (vc) begin
      dist_we    = 1'b1;
      dist_waddr = idxc;
      dist_wdata = new_dist;
    end
    pt_raddr = (state == ST_FETCH) ? pend_idx : walk[fps_pkg::IDX_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (pt_we) begin
      point_mem[points_loaded[fps_pkg::IDX_BITS-1:0]] <= s_tdata;
    end
    pt_rdata <= point_mem[pt_raddr];
  end

  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem[dist_waddr] <= dist_wdata;
    end
    dist_rdata <= dist_mem[walk[fps_pkg::IDX_BITS-1:0]];
  end

  // Distance pipeline payload.
  always_ff @(posedge clk) begin
    idx1  <= walk[fps_pkg::IDX_BITS-1:0];
    dxa   <= dx;
    dya   <= dy;
    dza   <= dz;
    dista <= dist_rdata;
    idxa  <= idx1;
    sqxb  <= px[fps_pkg::SQ_BITS-1:0];
    sqyb  <= py[fps_pkg::SQ_BITS-1:0];
    sqzb  <= pz[fps_pkg::SQ_BITS-1:0];
    distb <= dista;
    idxb  <= idxa;
    sumc  <= sum_full[fps_pkg::DIST_BITS-1:0];
    distc <= distb;
    idxc  <= idxb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      sample_count  <= fps_pkg::SCOUNT_BITS'(fps_pkg::SCOUNT_RESET);
      points_loaded <= '0;
      out_valid     <= 1'b0;
      v1            <= 1'b0;
      va            <= 1'b0;
      vb            <= 1'b0;
      vc            <= 1'b0;
      count         <= '0;
    end else begin
      if (cfg_we) begin
        sample_count <= cfg_data;
      end
      if (out_valid && m_tready && !out_load) begin
        out_valid <= 1'b0;
      end
      v1 <= (state == ST_SWEEP);
      va <= v1;
      vb <= va;
      vc <= vb;
      // The best candidate tracks the lowered distance; strict compare keeps the lowest index.
      if (vc && new_dist > best) begin
        best     <= new_dist;
        best_idx <= idxc;
      end
      unique case (state)
        ST_LOAD: begin
          if (s_acc) begin
            points_loaded <= n_next;
            if (s_tlast) begin
              n_pts    <= n_next;
              walk     <= '0;
              pend_idx <= '0;
              count    <= fps_pkg::SCOUNT_BITS'(1);
              if (fps_pkg::CNT_BITS'(want) >= n_next) begin
                state <= ST_ENUM;
              end else if (want == fps_pkg::SCOUNT_BITS'(1)) begin
                state <= ST_FINISH;
              end else begin
                state <= ST_FETCH;
              end
            end
          end
        end
        ST_ENUM: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_index <= walk[fps_pkg::IDX_BITS-1:0];
            out_last  <= (walk == n_pts - 1'b1);
            walk      <= walk + 1'b1;
            if (walk == n_pts - 1'b1) begin
              points_loaded <= '0;
              state         <= ST_LOAD;
            end
          end
        end
        ST_FETCH: begin
          state <= ST_LATCH;
        end
        ST_LATCH: begin
          cur_pt   <= pt_rdata;
          walk     <= '0;
          best     <= '0;
          best_idx <= '0;
          state    <= ST_SWEEP;
        end
        ST_SWEEP: begin
          walk <= walk + 1'b1;
          if (walk == n_pts - 1'b1) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!v1 && !va && !vb && !vc) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_index <= pend_idx;
            if (best == '0) begin
              out_last      <= 1'b1;
              points_loaded <= '0;
              state         <= ST_LOAD;
            end else begin
              out_last <= 1'b0;
              pend_idx <= best_idx;
              count    <= count + 1'b1;
              if (count + 1'b1 == want) begin
                state <= ST_FINISH;
              end else begin
                state <= ST_FETCH;
              end
            end
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            out_index     <= pend_idx;
            out_last      <= 1'b1;
            points_loaded <= '0;
            state         <= ST_LOAD;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // A new sweep must not start while lowered distances are still in flight.
  a_sweep_clean: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LATCH) |-> (!v1 && !va && !vb && !vc))
    else $error("sweep started with distance pipeline busy");

  // The number of chosen indices never exceeds the requested count.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state != ST_LOAD && state != ST_ENUM) |-> (count <= want))
    else $error("chosen index count exceeds request");

  // A winning candidate lies inside the loaded cloud.
  a_best_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DECIDE && best != '0) |-> (fps_pkg::CNT_BITS'(best_idx) < n_pts))
    else $error("farthest candidate outside loaded points");

  // Sweep write-back only happens while sampling.
  a_sweep_write: assert property (@(posedge clk) disable iff (rst)
    vc |-> (state == ST_SWEEP || state == ST_DRAIN))
    else $error("distance write-back outside a sweep");

endmodule
